### rtl/core/tacp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tacp_pkg;

  // Word widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ANGLE_FRAC = 8;
  localparam int unsigned ACC_FRAC   = 24;
  localparam int unsigned ROLL_W     = 17;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned RLIM_W     = 16;
  localparam int unsigned PLIM_W     = 15;
  localparam int unsigned CFG_W      = 16;

  // CORDIC sizing
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned TABLE_LEN    = 24;
  localparam int unsigned STEP_W       = $clog2(TABLE_LEN);
  // datapath: sample << ACC_FRAC, grown by sqrt(2) and the CORDIC gain
  localparam int unsigned CW           = SAMPLE_W + ACC_FRAC + 4;
  // angle accumulator in degrees with ACC_FRAC fraction bits, up to about 280 degrees
  localparam int unsigned AW           = ACC_FRAC + 11;
  localparam int unsigned TAG_W        = ROLL_W;

  // Inverse CORDIC gain, GAIN_INV / 2^GAIN_FRAC
  localparam int unsigned GAIN_FRAC = 20;
  localparam logic [GAIN_FRAC-1:0] GAIN_INV = GAIN_FRAC'(636750);

  // Rounding to output units
  localparam int unsigned ROUND_SH = ACC_FRAC - ANGLE_FRAC;
  localparam int unsigned OUT_W    = ROLL_W + 1;
  localparam longint      HALF_TURN_L = 180 * (64'sd1 <<< ACC_FRAC);
  localparam logic signed [AW-1:0]    HALF_TURN = AW'(HALF_TURN_L);
  localparam logic signed [AW-1:0]    HALF_LSB  = AW'(64'sd1 <<< (ROUND_SH - 1));
  localparam logic signed [OUT_W-1:0] ROLL_LIM  = OUT_W'(180 << ANGLE_FRAC);
  localparam logic signed [OUT_W-1:0] PITCH_LIM = OUT_W'(90 << ANGLE_FRAC);

  // Register reset values
  localparam logic [RLIM_W-1:0] ROLL_LIM_RST  = RLIM_W'(45 << ANGLE_FRAC);
  localparam logic [PLIM_W-1:0] PITCH_LIM_RST = PLIM_W'(40 << ANGLE_FRAC);

  typedef enum logic {
    REG_ROLL_LIMIT  = 1'b0,
    REG_PITCH_LIMIT = 1'b1
  } cfg_reg_e;

  // Word travelling down the cell chain
  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [AW-1:0]    ang;
    logic                    zero;
    logic signed [TAG_W-1:0] tag;
  } cell_t;

  // atan(2^-i) in degrees, ACC_FRAC fraction bits
  function automatic logic signed [AW-1:0] atan_lut(input logic [STEP_W-1:0] step);
    logic signed [AW-1:0] v;
    unique case (step)
      5'd0:  v = AW'(754974720);
      5'd1:  v = AW'(445687602);
      5'd2:  v = AW'(235489088);
      5'd3:  v = AW'(119537938);
      5'd4:  v = AW'(60000934);
      5'd5:  v = AW'(30029717);
      5'd6:  v = AW'(15018523);
      5'd7:  v = AW'(7509720);
      5'd8:  v = AW'(3754917);
      5'd9:  v = AW'(1877466);
      5'd10: v = AW'(938734);
      5'd11: v = AW'(469367);
      5'd12: v = AW'(234684);
      5'd13: v = AW'(117342);
      5'd14: v = AW'(58671);
      5'd15: v = AW'(29335);
      5'd16: v = AW'(14668);
      5'd17: v = AW'(7334);
      5'd18: v = AW'(3667);
      5'd19: v = AW'(1833);
      5'd20: v = AW'(917);
      5'd21: v = AW'(458);
      5'd22: v = AW'(229);
      5'd23: v = AW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up to output units, then clamp to +-lim
  function automatic logic signed [OUT_W-1:0] finish_angle(
    input logic signed [AW-1:0]    acc,
    input logic signed [OUT_W-1:0] lim
  );
    logic signed [AW-1:0]          sum;
    logic signed [AW-ROUND_SH-1:0] v;
    logic signed [OUT_W-1:0]       r;
    sum = acc + HALF_LSB;
    v   = sum[AW-1:ROUND_SH];
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tacp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vectoring micro-rotation, registered.
module tacp_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [tacp_pkg::STEP_W-1:0]  step_i,
  input  wire logic                         vld_i,
  input  wire tacp_pkg::cell_t              d_i,
  output logic                              vld_o,
  output tacp_pkg::cell_t                   q_o
);

  logic signed [tacp_pkg::CW-1:0] dx;
  logic signed [tacp_pkg::CW-1:0] dy;
  logic signed [tacp_pkg::AW-1:0] atn;
  tacp_pkg::cell_t                nxt;
  logic                           vld_q;
  tacp_pkg::cell_t                dat_q;

  always_comb begin
    dx  = $signed(d_i.y) >>> step_i;
    dy  = $signed(d_i.x) >>> step_i;
    atn = tacp_pkg::atan_lut(step_i);
    nxt = d_i;
    if (!d_i.y[tacp_pkg::CW-1]) begin
      nxt.x   = d_i.x + dx;
      nxt.y   = d_i.y - dy;
      nxt.ang = d_i.ang + atn;
    end else begin
      nxt.x   = d_i.x - dx;
      nxt.y   = d_i.y + dy;
      nxt.ang = d_i.ang - atn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= nxt;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = dat_q;

endmodule

`default_nettype wire

### rtl/core/tacp_gain.sv
`timescale 1ns / 1ps
`default_nettype none

// Between the chains: rounds roll, scales the magnitude by the inverse gain
// in two halves, and builds the pitch vector.
module tacp_gain (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire tacp_pkg::cell_t  d_i,
  output logic                  vld_o,
  output tacp_pkg::cell_t       q_o
);

  localparam int unsigned LO_W   = tacp_pkg::CW / 2;
  localparam int unsigned HI_W   = tacp_pkg::CW - LO_W;
  localparam int unsigned PP_W   = HI_W + tacp_pkg::GAIN_FRAC;
  localparam int unsigned PROD_W = tacp_pkg::CW + tacp_pkg::GAIN_FRAC;
  localparam int unsigned EXT_W  = tacp_pkg::CW - tacp_pkg::SAMPLE_W - tacp_pkg::ACC_FRAC;

  logic signed [tacp_pkg::AW-1:0]      roll_acc;
  logic signed [tacp_pkg::OUT_W-1:0]   roll_f;
  logic [PP_W-1:0]                     pp_lo_d, pp_hi_d;
  logic [PP_W-1:0]                     pp_lo_q, pp_hi_q;
  logic                                vld_a_q;
  logic [tacp_pkg::SAMPLE_W-1:0]       xs_a_q;
  logic signed [tacp_pkg::TAG_W-1:0]   roll_a_q;
  logic [PROD_W-1:0]                   prod;
  logic [tacp_pkg::CW-1:0]             mag;
  logic signed [tacp_pkg::CW-1:0]      xw;
  tacp_pkg::cell_t                     out_d;
  logic                                vld_b_q;
  tacp_pkg::cell_t                     out_q;

  // Stage A: round roll, partial products (magnitude is never negative)
  always_comb begin
    roll_acc = d_i.zero ? '0 : d_i.ang;
    roll_f   = tacp_pkg::finish_angle(roll_acc, tacp_pkg::ROLL_LIM);
    pp_lo_d  = PP_W'(d_i.x[LO_W-1:0]) * PP_W'(tacp_pkg::GAIN_INV);
    pp_hi_d  = PP_W'(d_i.x[tacp_pkg::CW-1:LO_W]) * PP_W'(tacp_pkg::GAIN_INV);
  end

  // Stage B: sum, truncate, pitch vector (magnitude, -x)
  always_comb begin
    prod      = PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) << LO_W);
    mag       = prod[tacp_pkg::GAIN_FRAC +: tacp_pkg::CW];
    xw        = {{EXT_W{xs_a_q[tacp_pkg::SAMPLE_W-1]}}, xs_a_q, {tacp_pkg::ACC_FRAC{1'b0}}};
    out_d.x   = mag;
    out_d.y   = -xw;
    out_d.ang = '0;
    out_d.zero = (mag == '0) && (xs_a_q == '0);
    out_d.tag = roll_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q  <= pp_lo_d;
      pp_hi_q  <= pp_hi_d;
      xs_a_q   <= d_i.tag[tacp_pkg::SAMPLE_W-1:0];
      roll_a_q <= tacp_pkg::TAG_W'(roll_f);
      out_q    <= out_d;
    end
  end

  assign vld_o = vld_b_q;
  assign q_o   = out_q;

endmodule

`default_nettype wire

### rtl/core/tilt_angle_tipover_check_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+---------------------------------------
// in      | in        | in_valid_i / in_ready_o   | accel_x_i, accel_y_i, accel_z_i
// out     | out       | out_valid_o / out_ready_i | roll_angle_o, pitch_angle_o, tip_over_o
// cfg     | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One word accepted per cycle unless out stalls; input to output passes 16
// roll cells, 2 gain-multiply stages, 16 pitch cells and the output register.
// The two CORDIC cell chains set the latency; every stage is fed forward.
// Reset clears the valid bits and loads the limits with 45 and 40 degrees.
// A stall on out freezes the whole pipe; in_ready_o is low only while a
// finished word sits in the output register and is not taken.
module tilt_angle_tipover_check_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // sample in
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [tacp_pkg::SAMPLE_W-1:0] accel_x_i,
  input  wire logic signed [tacp_pkg::SAMPLE_W-1:0] accel_y_i,
  input  wire logic signed [tacp_pkg::SAMPLE_W-1:0] accel_z_i,
  // angles out
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [tacp_pkg::ROLL_W-1:0]        roll_angle_o,
  output logic signed [tacp_pkg::PITCH_W-1:0]       pitch_angle_o,
  output logic                                      tip_over_o,
  // limit registers
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_idx_i,
  input  wire logic [tacp_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned EXT_W = tacp_pkg::CW - tacp_pkg::SAMPLE_W - tacp_pkg::ACC_FRAC;
  localparam int unsigned N     = tacp_pkg::CORDIC_STEPS;

  logic                            en;
  logic [tacp_pkg::RLIM_W-1:0]     roll_lim_q;
  logic [tacp_pkg::PLIM_W-1:0]     pitch_lim_q;

  // input prep
  logic signed [tacp_pkg::CW-1:0]  yw, zw;
  tacp_pkg::cell_t                 roll_in;

  // chains
  tacp_pkg::cell_t                 roll_c [0:N];
  logic                            roll_v [0:N];
  tacp_pkg::cell_t                 pitch_c [0:N];
  logic                            pitch_v [0:N];

  // output stage
  logic signed [tacp_pkg::AW-1:0]    pitch_acc;
  logic signed [tacp_pkg::OUT_W-1:0] pitch_f;
  logic signed [tacp_pkg::OUT_W-1:0] roll_x;
  logic [tacp_pkg::OUT_W-1:0]        roll_abs, pitch_abs;
  logic                              tip_d;
  logic                              out_vld_q;
  logic signed [tacp_pkg::ROLL_W-1:0]  roll_q;
  logic signed [tacp_pkg::PITCH_W-1:0] pitch_q;
  logic                                tip_q;

  // Whole pipe moves unless the output word is held
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_lim_q  <= tacp_pkg::ROLL_LIM_RST;
      pitch_lim_q <= tacp_pkg::PITCH_LIM_RST;
    end else if (cfg_we_i) begin
      unique case (tacp_pkg::cfg_reg_e'(cfg_idx_i))
        tacp_pkg::REG_ROLL_LIMIT:  roll_lim_q  <= cfg_data_i[tacp_pkg::RLIM_W-1:0];
        tacp_pkg::REG_PITCH_LIMIT: pitch_lim_q <= cfg_data_i[tacp_pkg::PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Roll vector (z, y); negative z is turned by half a turn, base +-180
  always_comb begin
    yw = {{EXT_W{accel_y_i[tacp_pkg::SAMPLE_W-1]}}, accel_y_i, {tacp_pkg::ACC_FRAC{1'b0}}};
    zw = {{EXT_W{accel_z_i[tacp_pkg::SAMPLE_W-1]}}, accel_z_i, {tacp_pkg::ACC_FRAC{1'b0}}};
    roll_in.zero = (accel_y_i == '0) && (accel_z_i == '0);
    roll_in.tag  = tacp_pkg::TAG_W'(accel_x_i);
    if (zw[tacp_pkg::CW-1]) begin
      roll_in.x   = -zw;
      roll_in.y   = -yw;
      roll_in.ang = yw[tacp_pkg::CW-1] ? -tacp_pkg::HALF_TURN : tacp_pkg::HALF_TURN;
    end else begin
      roll_in.x   = zw;
      roll_in.y   = yw;
      roll_in.ang = '0;
    end
  end

  assign roll_c[0] = roll_in;
  assign roll_v[0] = in_valid_i;

  for (genvar i = 0; i < N; i++) begin : g_roll
    tacp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (tacp_pkg::STEP_W'(i)),
      .vld_i  (roll_v[i]),
      .d_i    (roll_c[i]),
      .vld_o  (roll_v[i+1]),
      .q_o    (roll_c[i+1])
    );
  end

  // Roll rounding and magnitude scaling; roll rides on in tag
  tacp_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (roll_v[N]),
    .d_i    (roll_c[N]),
    .vld_o  (pitch_v[0]),
    .q_o    (pitch_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_pitch
    tacp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (tacp_pkg::STEP_W'(i)),
      .vld_i  (pitch_v[i]),
      .d_i    (pitch_c[i]),
      .vld_o  (pitch_v[i+1]),
      .q_o    (pitch_c[i+1])
    );
  end

  // Pitch rounding, magnitudes and strict limit compare
  always_comb begin
    pitch_acc = pitch_c[N].zero ? '0 : pitch_c[N].ang;
    pitch_f   = tacp_pkg::finish_angle(pitch_acc, tacp_pkg::PITCH_LIM);
    roll_x    = tacp_pkg::OUT_W'(pitch_c[N].tag);
    roll_abs  = roll_x[tacp_pkg::OUT_W-1] ? tacp_pkg::OUT_W'(-roll_x) : roll_x;
    pitch_abs = pitch_f[tacp_pkg::OUT_W-1] ? tacp_pkg::OUT_W'(-pitch_f) : pitch_f;
    tip_d     = (roll_abs > tacp_pkg::OUT_W'(roll_lim_q)) ||
                (pitch_abs > tacp_pkg::OUT_W'(pitch_lim_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pitch_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= pitch_c[N].tag;
      pitch_q <= tacp_pkg::PITCH_W'(pitch_f);
      tip_q   <= tip_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign tip_over_o    = tip_q;

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the tilt / tip-over block.
// Each accepted sample word is run through a local fixed-point CORDIC
// predictor (roll, gain-corrected magnitude, pitch, limit compare); the
// prediction is queued and compared field by field with the next word taken
// on the out channel. Limits are rewritten only with the pipe empty.
module tb_top;

  localparam int STEPS      = tacp_pkg::CORDIC_STEPS;
  localparam int ACC_FB     = 24;       // fraction bits inside the CORDIC
  localparam int OUT_FB     = 8;        // fraction bits of the output angles
  localparam int GAIN_SH    = 20;
  localparam int N_DIR      = 23;
  localparam int N_PHASE    = 6;
  localparam int PHASE_LEN  = 205;
  localparam int HOLD_CYC   = 150;      // long out-side stall, fills the pipe
  localparam int TAIL_CYC   = 40;       // a little longer than the pipe latency
  localparam int CYCLE_CAP  = 150000;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [tacp_pkg::ROLL_W-1:0]  roll;
    logic [tacp_pkg::PITCH_W-1:0] pitch;
    logic                         tip;
  } tilt_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               typed;  // expected word given in the row itself
    tilt_t              res;
  } row_t;

  typedef enum int {
    AX_ANY,    // anything in range
    AX_TINY,   // a few counts around zero
    AX_ONE_G,  // roughly one g, either sign
    AX_TILT,   // moderate side component
    AX_EDGE    // limits of the two's complement range
  } axis_kind_e;

  localparam tilt_t ZERO_RES = '{roll: '0, pitch: '0, tip: 1'b0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic signed [15:0] ax = '0;
  logic signed [15:0] ay = '0;
  logic signed [15:0] az = '0;
  logic               out_ready = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_idx = 1'b0;
  logic [15:0]        cfg_data = '0;

  wire                                  in_ready_o;
  wire                                  out_valid_o;
  wire signed [tacp_pkg::ROLL_W-1:0]    roll_angle_o;
  wire signed [tacp_pkg::PITCH_W-1:0]   pitch_angle_o;
  wire                                  tip_over_o;

  // side information riding with the word on offer
  logic  cur_typed = 1'b0;
  tilt_t cur_res = '0;

  // local copy of the limit registers
  logic [15:0] roll_lim  = tacp_pkg::ROLL_LIM_RST;
  logic [14:0] pitch_lim = tacp_pkg::PITCH_LIM_RST;

  tilt_t angle_q [$];

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int fail_count = 0;
  int samples_sent = 0;
  int words_checked = 0;
  int limit_sets = 0;
  int cycles = 0;

  row_t dir_tab [0:N_DIR-1] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, ZERO_RES},  // zero vector
    '{16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   1'b0, ZERO_RES},
    '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, ZERO_RES},
    '{16'sh8000,   16'sd0,      16'sd0,      1'b0, ZERO_RES},  // pitch only, +90
    '{16'sh7FFF,   16'sd0,      16'sd0,      1'b0, ZERO_RES},  // pitch only, -90
    '{16'sd0,      16'sd0,      16'sh7FFF,   1'b0, ZERO_RES},
    '{16'sd0,      16'sd0,      16'sh8000,   1'b0, ZERO_RES},  // z negative, y zero: +180
    '{16'sd0,      -16'sd1,     16'sh8000,   1'b0, ZERO_RES},  // z negative, y < 0: -180
    '{16'sd0,      16'sd1,      16'sh8000,   1'b0, ZERO_RES},
    '{16'sd0,      16'sh7FFF,   16'sd0,      1'b0, ZERO_RES},
    '{16'sd0,      16'sh8000,   16'sd0,      1'b0, ZERO_RES},
    '{16'sd0,      16'sh8000,   16'sh8000,   1'b0, ZERO_RES},
    '{16'sh8000,   16'sh7FFF,   16'sh8000,   1'b0, ZERO_RES},
    '{16'sd0,      16'sd0,      16'sd1,      1'b0, ZERO_RES},
    '{16'sd0,      16'sd0,      -16'sd1,     1'b0, ZERO_RES},
    '{16'sd1,      16'sd0,      16'sd0,      1'b0, ZERO_RES},
    '{-16'sd1,     16'sd0,      16'sd0,      1'b0, ZERO_RES},
    '{16'sd0,      16'sd16384,  16'sd16384,  1'b0, ZERO_RES},  // roll on the 45 deg limit
    '{16'sd0,      -16'sd16384, 16'sd16384,  1'b0, ZERO_RES},
    '{16'sd16384,  16'sd0,      16'sd16384,  1'b0, ZERO_RES},  // pitch past 40 deg
    '{-16'sd16384, 16'sd0,      16'sd16384,  1'b0, ZERO_RES},
    '{16'sd5,      16'sd3,      -16'sd4,     1'b0, ZERO_RES},
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, ZERO_RES}   // zero again after big words
  };

  tilt_angle_tipover_check_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .accel_x_i     (ax),
    .accel_y_i     (ay),
    .accel_z_i     (az),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .tip_over_o    (tip_over_o),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Vectoring CORDIC, x >= 0 on entry; returns the angle, mag_o = |v| * gain.
  function automatic longint vector_angle(input longint xi, input longint yi,
                                          output longint mag_o);
    longint x, y, ang, dx, dy, step;
    int i;
    x = xi;
    y = yi;
    ang = 0;
    for (i = 0; i < STEPS; i++) begin
      // atan(2^-i) in degrees, 24 fraction bits
      case (i)
        0:  step = 754974720;
        1:  step = 445687602;
        2:  step = 235489088;
        3:  step = 119537938;
        4:  step = 60000934;
        5:  step = 30029717;
        6:  step = 15018523;
        7:  step = 7509720;
        8:  step = 3754917;
        9:  step = 1877466;
        10: step = 938734;
        11: step = 469367;
        12: step = 234684;
        13: step = 117342;
        14: step = 58671;
        15: step = 29335;
        16: step = 14668;
        17: step = 7334;
        18: step = 3667;
        19: step = 1833;
        20: step = 917;
        21: step = 458;
        22: step = 229;
        23: step = 115;
        default: step = 0;
      endcase
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + step;
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - step;
      end
    end
    mag_o = x;
    return ang;
  endfunction

  // half-up rounding to output units, then clamp to +-lim_deg
  function automatic longint round_clamp(input longint acc, input int lim_deg);
    longint v, lim;
    v = (acc + (longint'(1) <<< (ACC_FB - OUT_FB - 1))) >>> (ACC_FB - OUT_FB);
    lim = longint'(lim_deg) <<< OUT_FB;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic tilt_t predict_tilt(input logic signed [15:0] sx,
                                         input logic signed [15:0] sy,
                                         input logic signed [15:0] sz);
    longint x, y, z, base, roll_acc, pitch_acc, mag, spare, roll, pitch, ar, ap;
    longint unsigned prod;
    tilt_t r;
    x = longint'(sx) <<< ACC_FB;
    y = longint'(sy) <<< ACC_FB;
    z = longint'(sz) <<< ACC_FB;
    roll_acc = 0;
    pitch_acc = 0;
    mag = 0;
    if (y != 0 || z != 0) begin
      if (z < 0) begin
        // turn the vector half way round and start from +-180
        base = longint'(180) <<< ACC_FB;
        if (y < 0) base = -base;
        roll_acc = base + vector_angle(-z, -y, mag);
      end else begin
        roll_acc = vector_angle(z, y, mag);
      end
    end
    // strip the CORDIC gain, truncating
    prod = mag;
    prod = (prod * 64'd636750) >> GAIN_SH;
    mag = longint'(prod);
    if (mag != 0 || x != 0) pitch_acc = vector_angle(mag, -x, spare);
    roll  = round_clamp(roll_acc, 180);
    pitch = round_clamp(pitch_acc, 90);
    ar = (roll < 0) ? -roll : roll;
    ap = (pitch < 0) ? -pitch : pitch;
    r.roll  = roll[tacp_pkg::ROLL_W-1:0];
    r.pitch = pitch[tacp_pkg::PITCH_W-1:0];
    r.tip   = (ar > longint'(roll_lim)) || (ap > longint'(pitch_lim));
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    if (fail_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // expectation queued on every accepted sample word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) begin
      angle_q.push_back(cur_typed ? cur_res : predict_tilt(ax, ay, az));
      samples_sent++;
    end
  end

  // every word taken on out is matched with the oldest expectation
  always @(posedge clk_i) begin
    tilt_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (angle_q.size() == 0) begin
        report_mismatch("word with nothing expected", roll_angle_o, 0);
      end else begin
        want = angle_q.pop_front();
        words_checked++;
        if (roll_angle_o !== want.roll)
          report_mismatch("roll_angle", roll_angle_o, want.roll);
        if (pitch_angle_o !== want.pitch)
          report_mismatch("pitch_angle", pitch_angle_o, want.pitch);
        if (tip_over_o !== want.tip)
          report_mismatch("tip_over", tip_over_o, want.tip);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Out side: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long stall; the pipe fills and in_ready_o must drop
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // In side
  // ---------------------------------------------------------------------

  // offer one word, with an occasional gap in front, and wait for acceptance
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic typed,
                             input tilt_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    ax        <= x;
    ay        <= y;
    az        <= z;
    cur_typed <= typed;
    cur_res   <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [15:0] axis_value(input axis_kind_e kind);
    logic signed [15:0] v;
    case (kind)
      AX_TINY:  v = 16'($urandom_range(0, 8)) - 16'sd4;
      AX_ONE_G: v = 16'($urandom_range(14000, 18000));
      AX_TILT:  v = 16'($urandom_range(0, 6000));
      AX_EDGE: begin
        case ($urandom_range(0, 5))
          0:       v = 16'sh8000;
          1:       v = 16'sh8001;
          2:       v = -16'sd1;
          3:       v = 16'sd0;
          4:       v = 16'sd1;
          default: v = 16'sh7FFF;
        endcase
      end
      default:  v = 16'($urandom);
    endcase
    if (kind inside {AX_ONE_G, AX_TILT} && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic send_random();
    logic signed [15:0] x, y, z;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = axis_value(AX_ANY);
        y = axis_value(AX_ANY);
        z = axis_value(AX_ANY);
      end
      4, 5: begin
        // sensor near rest, one axis carrying gravity
        x = axis_value(AX_TILT);
        y = axis_value(AX_TILT);
        z = axis_value(AX_TILT);
        case ($urandom_range(0, 2))
          0:       x = axis_value(AX_ONE_G);
          1:       y = axis_value(AX_ONE_G);
          default: z = axis_value(AX_ONE_G);
        endcase
      end
      6: begin
        // upside down with y close to zero: roll sits at the +-180 seam
        x = axis_value(AX_ANY);
        y = 16'($urandom_range(0, 2)) - 16'sd1;
        z = -16'($urandom_range(1, 32768));
      end
      7: begin
        // y and z both zero: pitch alone
        x = axis_value($urandom_range(0, 1) ? AX_ANY : AX_EDGE);
        y = '0;
        z = '0;
      end
      8: begin
        x = axis_value(AX_TINY);
        y = axis_value(AX_TINY);
        z = axis_value(AX_TINY);
      end
      default: begin
        x = axis_value(AX_EDGE);
        y = axis_value(AX_EDGE);
        z = axis_value(AX_EDGE);
      end
    endcase
    send_sample(x, y, z, 1'b0, ZERO_RES);
  endtask

  // stop offering and wait until the pipe has delivered everything
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  // both limits, back to back; only called with the pipe empty
  task automatic set_limits(input logic [15:0] roll_v, input logic [15:0] pitch_v);
    cfg_we   <= 1'b1;
    cfg_idx  <= tacp_pkg::REG_ROLL_LIMIT;
    cfg_data <= roll_v;
    @(posedge clk_i);
    cfg_idx  <= tacp_pkg::REG_PITCH_LIMIT;
    cfg_data <= pitch_v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    roll_lim  = roll_v;
    pitch_lim = pitch_v[14:0];  // register is 15 bits wide, top bit dropped
    limit_sets++;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] roll_set [N_PHASE];
    logic [15:0] pitch_set [N_PHASE];
    int p, k;

    // limit settings per phase: both extremes, the documented maxima,
    // the reset values again, and random ones (pitch with a stray top bit)
    roll_set[0]  = 16'd0;      pitch_set[0] = 16'd0;
    roll_set[1]  = 16'hFFFF;   pitch_set[1] = 16'hFFFF;
    roll_set[2]  = 16'd46080;  pitch_set[2] = 16'd23040;
    roll_set[3]  = 16'($urandom_range(0, 46080));
    pitch_set[3] = 16'($urandom);
    roll_set[4]  = 16'd11520;  pitch_set[4] = 16'd10240;
    roll_set[5]  = 16'($urandom_range(0, 46080));
    pitch_set[5] = 16'($urandom_range(0, 23040));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset limits
    for (k = 0; k < N_DIR; k++)
      send_sample(dir_tab[k].x, dir_tab[k].y, dir_tab[k].z, dir_tab[k].typed,
                  dir_tab[k].res);

    for (p = 0; p < N_PHASE; p++) begin
      drain_pipe();
      set_limits(roll_set[p], pitch_set[p]);
      if (p == 1) hold_req = 1'b1;
      for (k = 0; k < PHASE_LEN; k++) begin
        // alternate stretches with and without idling; none at the very end
        idle_on = (p != N_PHASE - 1) && ((k / 40) % 3 != 2);
        send_random();
      end
    end

    drain_pipe();

    $display("Summary: %0d sample words (%0d directed) over %0d limit settings,",
             samples_sent, N_DIR, limit_sets + 1);
    $display("  incl. a %0d-cycle output stall and drain pauses; %0d words checked",
             HOLD_CYC, words_checked);
    if (fail_count == 0 && angle_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
